// ----- rtl/talm_pkg.sv -----
// ----------------------------------------------------------------------------
// talm_pkg
// Types, constants and codes shared by the timed audio level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package talm_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam logic [15:0] MIN_DUR_RST = 16'd1;
    localparam logic [15:0] MAX_DUR_RST = 16'd300;
    localparam logic [15:0] CLIP_LEVEL  = 16'd32760;
    localparam logic [9:0]  MS_PER_S    = 10'd1000;
    localparam logic [14:0] PCT_SCALE   = 15'd25600;

    typedef enum logic [1:0] {
        FN_START  = 2'd0,
        FN_SAMPLE = 2'd1,
        FN_QUERY  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        PH_NOT_RUN = 2'd0,
        PH_RUNNING = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    typedef enum logic [0:0] {
        CFG_MIN_DUR = 1'b0,
        CFG_MAX_DUR = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] sample;
        logic               frame_start;
        logic [15:0]        duration_s;
        logic [63:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic [1:0]         run_state;
        logic [31:0]        session_number;
        logic [31:0]        frames_seen;
        logic [31:0]        samples_seen;
        logic [15:0]        peak_level;
        logic [31:0]        clip_total;
        logic [23:0]        rms_level;
        logic signed [23:0] dc_level;
        logic [14:0]        clip_percent;
    } t_out_item;

    typedef enum logic [1:0] {
        DOP_DIV  = 2'd0,
        DOP_SQRT = 2'd1
    } t_dop;

    typedef struct packed {
        logic start;
        t_dop op;
    } t_du_req;

endpackage

`default_nettype wire

// ----- rtl/talm_divsqrt.sv -----
// ----------------------------------------------------------------------------
// talm_divsqrt
// Shared bit-serial unit: 80-bit by 32-bit restoring divide, one quotient
// bit a cycle, or 80-bit integer square root, one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module talm_divsqrt (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire talm_pkg::t_du_req i_req,
    input  wire logic [79:0]       i_num,
    input  wire logic [31:0]       i_den,
    output logic                   o_done,
    output logic [79:0]            o_res
);
    import talm_pkg::*;

    logic [79:0] r_q, n_q;
    logic [81:0] r_rem, n_rem;
    logic [41:0] r_root, n_root;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_sq, n_sq;
    logic        r_done, n_done;
    logic [31:0] r_den;
    logic [81:0] trial;
    logic [81:0] shifted;
    logic [41:0] cand;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_root = r_root; n_cnt = r_cnt;
        n_busy = r_busy; n_sq = r_sq; n_done = 1'b0;
        shifted = '0; trial = '0; cand = '0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_sq = (i_req.op == DOP_SQRT);
            n_q = i_num;
            n_rem = '0;
            n_root = '0;
            n_cnt = (i_req.op == DOP_SQRT) ? 7'd40 : 7'd80;
        end else if (r_busy) begin
            if (r_sq) begin
                shifted = {r_rem[79:0], r_q[79:78]};
                cand = {r_root[39:0], 2'b01};
                trial = shifted - {40'd0, cand};
                n_q = {r_q[77:0], 2'b00};
                if (!trial[81]) begin
                    n_rem = trial;
                    n_root = {r_root[40:0], 1'b1};
                end else begin
                    n_rem = shifted;
                    n_root = {r_root[40:0], 1'b0};
                end
            end else begin
                shifted = {r_rem[80:0], r_q[79]};
                trial = shifted - {50'd0, r_den};
                if (!trial[81]) begin
                    n_rem = trial;
                    n_q = {r_q[78:0], 1'b1};
                end else begin
                    n_rem = shifted;
                    n_q = {r_q[78:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_sq   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_sq   <= n_sq;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        r_root <= n_root;
        if (i_req.start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_res  = r_sq ? {38'd0, r_root} : r_q;

endmodule

`default_nettype wire

// ----- rtl/timed_audio_level_meter_unit.sv -----
// ----------------------------------------------------------------------------
// timed_audio_level_meter_unit
// Timed level-meter session: accumulates sample statistics and reports
// RMS, DC offset and clip percent on start and query transactions.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | in        | i_in_valid/o_in_ready | t_in_item
// out     | out       | o_out_valid/i_out_ready | t_out_item
// cfg     | in        | i_cfg_valid/o_cfg_ready | index, data
//
// A sample transaction is captured with its magnitude, then squared, then accumulated.
// Start/query results come from the shared serial divide/sqrt unit (three
// 80-step divides, then one 40-step root, each with a launch state and a
// wait-for-done state); the unit is not used when the session has no samples.
// Reset is synchronous; no clearing pass. Output register holds until taken;
// a further start/query waits in its last state until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_audio_level_meter_unit #(
    parameter int COUNT_WIDTH = talm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire talm_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output talm_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [0:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);
    import talm_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ACC, S_EVAL, S_D1, S_D1W, S_D2, S_D2W,
        S_D3, S_D3W, S_SQRT, S_SQRTW, S_OUT
    } t_state;

    t_state r_st, n_st;
    t_in_item r_in;
    logic [15:0] r_min, r_max;
    t_phase r_ph;
    logic [31:0] r_cur, r_next;
    logic [63:0] r_end;
    logic r_fc;
    logic [COUNT_WIDTH-1:0] r_frames, r_samples, r_clips;
    logic signed [47:0] r_sum;
    logic [63:0] r_sq;
    logic [15:0] r_peak;
    logic [16:0] r_mag;
    logic [33:0] r_prod;
    logic r_ok;
    logic [79:0] r_a;
    logic [23:0] r_dc;
    logic [14:0] r_pct;
    logic [23:0] r_rms;
    logic r_neg;
    t_out_item r_out;
    logic r_oval;

    t_du_req du_req;
    logic [79:0] du_num, du_res;
    logic [31:0] du_den;
    logic du_done;

    talm_divsqrt u_du (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(du_req),
        .i_num(du_num), .i_den(du_den), .o_done(du_done), .o_res(du_res)
    );

    logic expired;
    logic [47:0] abs_sum;
    logic [31:0] n32;
    assign expired = (r_ph == PH_RUNNING) && (r_in.now_ms >= r_end);
    assign abs_sum = r_sum[47] ? (48'd0 - r_sum) : r_sum;
    assign n32 = 32'(r_samples);

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_in_valid) begin
                n_st = (i_in_data.func == FN_SAMPLE) ? S_SQ :
                       (i_in_data.func == FN_NONE) ? S_IDLE : S_EVAL;
            end
            S_SQ:    n_st = S_ACC;
            S_ACC:   n_st = S_IDLE;
            S_EVAL:  n_st = S_D1;
            S_D1:    n_st = (r_samples == '0) ? S_OUT : S_D1W;
            S_D1W:   if (du_done) n_st = S_D2;
            S_D2:    n_st = S_D2W;
            S_D2W:   if (du_done) n_st = S_D3;
            S_D3:    n_st = S_D3W;
            S_D3W:   if (du_done) n_st = S_SQRT;
            S_SQRT:  n_st = S_SQRTW;
            S_SQRTW: if (du_done) n_st = S_OUT;
            S_OUT:   if (!r_oval) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // divide sequence: sq*65536/n ; |sum|*256/n ; clip*25600/n ; sqrt
    always_comb begin
        du_req = '{start: 1'b0, op: DOP_DIV};
        du_num = '0;
        du_den = n32;
        case (r_st)
            S_D1: begin
                du_req.start = (r_samples != '0);
                du_num = {r_sq, 16'd0};
            end
            S_D2: begin
                du_req.start = 1'b1;
                du_num = {abs_sum, 32'd0} >> 24;
            end
            S_D3: begin
                du_req.start = 1'b1;
                du_num = 80'(r_clips) * 80'(PCT_SCALE);
            end
            S_SQRT: begin
                du_req = '{start: 1'b1, op: DOP_SQRT};
                du_num = r_a;
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE);
    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_min <= MIN_DUR_RST;
            r_max <= MAX_DUR_RST;
            r_ph <= PH_NOT_RUN;
            r_cur <= '0;
            r_next <= 32'd1;
            r_end <= '0;
            r_fc <= 1'b0;
            r_frames <= '0;
            r_samples <= '0;
            r_clips <= '0;
            r_sum <= '0;
            r_sq <= '0;
            r_peak <= '0;
            r_oval <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_oval && i_out_ready) r_oval <= 1'b0;
            if (i_cfg_valid && r_st == S_IDLE) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MIN_DUR: r_min <= i_cfg_data;
                    CFG_MAX_DUR: r_max <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: if (i_in_valid) begin
                    r_in <= i_in_data;
                    r_mag <= i_in_data.sample[15]
                        ? (17'd0 - {i_in_data.sample[15], i_in_data.sample})
                        : {1'b0, i_in_data.sample};
                end
                S_SQ: begin
                    if (r_in.frame_start) begin
                        if (expired) begin
                            r_ph <= PH_DONE;
                            r_fc <= 1'b0;
                        end else begin
                            r_fc <= (r_ph == PH_RUNNING);
                            if (r_ph == PH_RUNNING && r_frames != CNT_MAX)
                                r_frames <= r_frames + 1'b1;
                        end
                    end
                end
                S_ACC: begin
                    if (r_fc && r_samples != CNT_MAX) begin
                        r_samples <= r_samples + 1'b1;
                        r_sum <= r_sum + 48'(r_in.sample);
                        r_sq <= r_sq + 64'(r_prod);
                        if (r_mag[15:0] > r_peak || r_mag[16]) r_peak <= r_mag[15:0];
                        if (r_mag >= 17'(CLIP_LEVEL) && r_clips != CNT_MAX)
                            r_clips <= r_clips + 1'b1;
                    end
                end
                S_EVAL: begin
                    r_ok <= (r_in.func == FN_QUERY);
                    if (r_in.func == FN_START && r_in.duration_s >= r_min &&
                        r_in.duration_s <= r_max && (r_ph != PH_RUNNING || expired)) begin
                        r_ok <= 1'b1;
                        r_cur <= r_next;
                        r_next <= (r_next == 32'hFFFF_FFFF) ? 32'd1 : r_next + 32'd1;
                        r_end <= r_in.now_ms + 64'(r_in.duration_s) * 64'(MS_PER_S);
                        r_fc <= 1'b0;
                        r_frames <= '0;
                        r_samples <= '0;
                        r_sum <= '0;
                        r_sq <= '0;
                        r_peak <= '0;
                        r_clips <= '0;
                        r_ph <= PH_RUNNING;
                    end else if (expired) begin
                        r_ph <= PH_DONE;
                    end
                    r_neg <= 1'b0;
                end
                S_D1: begin
                    r_rms <= '0; r_dc <= '0; r_pct <= '0;
                    r_neg <= r_sum[47];
                end
                S_D1W: if (du_done) r_a <= du_res;
                S_D2W: if (du_done) r_dc <= r_neg ? 24'(24'd0 - du_res[23:0]) : du_res[23:0];
                S_D3W: if (du_done) r_pct <= du_res[14:0];
                S_SQRTW: if (du_done) r_rms <= du_res[23:0];
                S_OUT: if (!r_oval) begin
                    r_oval <= 1'b1;
                    r_out <= '{ok: r_ok, run_state: r_ph, session_number: r_cur,
                        frames_seen: 32'(r_frames), samples_seen: 32'(r_samples),
                        peak_level: r_peak, clip_total: 32'(r_clips),
                        rms_level: r_rms, dc_level: r_dc, clip_percent: r_pct};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 34'(r_mag) * 34'(r_mag);
    end

endmodule

`default_nettype wire
